/* src/spf_ip_prefix_first_match_assert.svh */
// Assertion macros shared by the checker of the SPF prefix match block.
`ifndef SPF_IP_PREFIX_FIRST_MATCH_ASSERT_SVH
`define SPF_IP_PREFIX_FIRST_MATCH_ASSERT_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define SPFM_ASSERT_SAME(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define SPFM_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

/* src/spfm_pkg.sv */
// Types and constants of the SPF prefix match block.
`timescale 1ns / 1ps
package spfm_pkg;

   localparam int ADDR_W   = 64;
   localparam int PREFIX_W = 8;
   localparam int INDEX_W  = 4;
   localparam int CODE_W   = 2;
   localparam int COUNT_W  = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_CHECK = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERM_FAILED  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_FAILED  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NEUTRAL_CODE = 2'd3;

   localparam logic [CODE_W-1:0] VERDICT_PERM  = 2'd0;
   localparam logic [CODE_W-1:0] VERDICT_TEMP  = 2'd1;
   localparam logic [CODE_W-1:0] NEUTRAL_RESET = 2'd2;

   localparam logic [PREFIX_W-1:0] IPV4_BITS = 8'd32;
   localparam logic [PREFIX_W-1:0] IPV6_BITS = 8'd128;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_HOLD_HIT,
      ST_HOLD_DFLT
   } spfm_state_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   addr_high;
      logic [ADDR_W-1:0]   addr_low;
      logic [PREFIX_W-1:0] prefix_len;
      logic                tempfail;
      logic                any;
      logic                ipv6;
      logic                ipv4;
      logic [CODE_W-1:0]   mech_code;
   } spfm_entry_type;

   typedef struct packed {
      logic write_entry;
      logic load_query;
      logic read_en;
      logic load_rsp;
      logic use_default;
   } spfm_cmd_type;

   typedef struct packed {
      logic hit;
      logic rsp_free;
   } spfm_status_type;

endpackage

/* src/spf_ip_prefix_first_match.sv */
// Top level of the SPF first-match address prefix block.
`timescale 1ns / 1ps
//
//   channel  direction  handshake            carries
//   req      in         req_valid/req_ready  table entry write or address check
//   rsp      out        rsp_valid/rsp_ready  verdict of one address check
//   csr      in         csr_valid/csr_ready  config register index and data
//
// Table write: stored when the request transfers. Check: entries 0 to n-1 are walked
// (n = entry_count clamped to TABLE_ENTRIES), one entry read per cycle and compared
// from the read register; the first hit gives the verdict, else the default does.
// Synchronous reset clears control, result valid and config; the table is undefined
// until written. Input is taken while a verdict waits; a finished check holds until
// the output register frees up.
module spf_ip_prefix_first_match #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_mode,
   input  logic [spfm_pkg::INDEX_W-1:0]        req_entry_index,
   input  logic [spfm_pkg::CODE_W-1:0]         req_mech_code,
   input  logic                                req_flag_ipv4,
   input  logic                                req_flag_ipv6,
   input  logic                                req_flag_any,
   input  logic                                req_flag_tempfail,
   input  logic [spfm_pkg::PREFIX_W-1:0]       req_prefix_len,
   input  logic [spfm_pkg::ADDR_W-1:0]         req_addr_high,
   input  logic [spfm_pkg::ADDR_W-1:0]         req_addr_low,
   input  logic                                req_query_is_ipv6,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_verdict_true,
   output logic [spfm_pkg::CODE_W-1:0]         rsp_verdict_code,
   output logic [spfm_pkg::INDEX_W-1:0]        rsp_matched_index,
   output logic                                rsp_used_default,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [spfm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [spfm_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import spfm_pkg::*;

   // table address width; a one-entry table still needs one address bit
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   spfm_cmd_type       cmd;
   spfm_status_type    status;
   logic [IDX_W-1:0]   rd_addr;
   logic [IDX_W-1:0]   match_idx;
   logic [COUNT_W-1:0] entry_count;

   // sequence the transfers and the table walk
   spfm_ctrl #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .IDX_W         (IDX_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_mode    (req_mode),
      .entry_count (entry_count),
      .status      (status),
      .cmd         (cmd),
      .rd_addr     (rd_addr),
      .match_idx   (match_idx)
   );

   // hold the table, compare entries, build and hold the verdict
   spfm_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .IDX_W         (IDX_W)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_entry_index   (req_entry_index),
      .req_mech_code     (req_mech_code),
      .req_flag_ipv4     (req_flag_ipv4),
      .req_flag_ipv6     (req_flag_ipv6),
      .req_flag_any      (req_flag_any),
      .req_flag_tempfail (req_flag_tempfail),
      .req_prefix_len    (req_prefix_len),
      .req_addr_high     (req_addr_high),
      .req_addr_low      (req_addr_low),
      .req_query_is_ipv6 (req_query_is_ipv6),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .cmd               (cmd),
      .status            (status),
      .rd_addr           (rd_addr),
      .match_idx         (match_idx),
      .entry_count       (entry_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_verdict_true  (rsp_verdict_true),
      .rsp_verdict_code  (rsp_verdict_code),
      .rsp_matched_index (rsp_matched_index),
      .rsp_used_default  (rsp_used_default)
   );

endmodule

/* src/spfm_ctrl.sv */
// Controller: accepts items, walks the table and decides when to post a result.
`timescale 1ns / 1ps
module spfm_ctrl #(
   parameter int TABLE_ENTRIES = 16,
   parameter int IDX_W = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_mode,
   input  logic [spfm_pkg::COUNT_W-1:0]     entry_count,
   input  spfm_pkg::spfm_status_type        status,
   output spfm_pkg::spfm_cmd_type           cmd,
   output logic [IDX_W-1:0]                 rd_addr,
   output logic [IDX_W-1:0]                 match_idx
);
   import spfm_pkg::*;

   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   spfm_state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic [CNT_W-1:0] walk_limit;
   logic             walk_end;

   // clamp the walk to the table depth
   assign walk_limit = (32'(entry_count) > 32'(TABLE_ENTRIES)) ? CNT_W'(TABLE_ENTRIES)
                                                              : CNT_W'(entry_count);
   assign walk_end   = (cnt_ff == walk_limit);
   assign rd_addr    = cnt_ff[IDX_W-1:0];
   assign match_idx  = cmp_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= cmp_idx_in;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_mode == MODE_CHECK) begin
                  cmd.load_query = 1'b1;
                  cnt_in         = '0;
                  state_in       = ST_WALK;
               end else begin
                  cmd.write_entry = 1'b1;
               end
            end
         end
         ST_WALK: begin
            if (cmp_valid_ff && status.hit) begin
               if (status.rsp_free) begin
                  cmd.load_rsp = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_HOLD_HIT;
               end
            end else if (!cmp_valid_ff && walk_end) begin
               if (status.rsp_free) begin
                  cmd.load_rsp    = 1'b1;
                  cmd.use_default = 1'b1;
                  state_in        = ST_IDLE;
               end else begin
                  state_in = ST_HOLD_DFLT;
               end
            end else if (!walk_end) begin
               cmd.read_en  = 1'b1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = cnt_ff[IDX_W-1:0];
               cnt_in       = cnt_ff + CNT_W'(1);
            end
         end
         ST_HOLD_HIT: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_HOLD_DFLT: begin
            if (status.rsp_free) begin
               cmd.load_rsp    = 1'b1;
               cmd.use_default = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* src/spfm_datapath.sv */
// Datapath: entry table, query and config registers, prefix compare, result register.
`timescale 1ns / 1ps
module spfm_datapath #(
   parameter int TABLE_ENTRIES = 16,
   parameter int IDX_W = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [spfm_pkg::INDEX_W-1:0]        req_entry_index,
   input  logic [spfm_pkg::CODE_W-1:0]         req_mech_code,
   input  logic                                req_flag_ipv4,
   input  logic                                req_flag_ipv6,
   input  logic                                req_flag_any,
   input  logic                                req_flag_tempfail,
   input  logic [spfm_pkg::PREFIX_W-1:0]       req_prefix_len,
   input  logic [spfm_pkg::ADDR_W-1:0]         req_addr_high,
   input  logic [spfm_pkg::ADDR_W-1:0]         req_addr_low,
   input  logic                                req_query_is_ipv6,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [spfm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [spfm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  spfm_pkg::spfm_cmd_type              cmd,
   output spfm_pkg::spfm_status_type           status,
   input  logic [IDX_W-1:0]                    rd_addr,
   input  logic [IDX_W-1:0]                    match_idx,
   output logic [spfm_pkg::COUNT_W-1:0]        entry_count,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_verdict_true,
   output logic [spfm_pkg::CODE_W-1:0]         rsp_verdict_code,
   output logic [spfm_pkg::INDEX_W-1:0]        rsp_matched_index,
   output logic                                rsp_used_default
);
   import spfm_pkg::*;

   spfm_entry_type            mem [TABLE_ENTRIES];
   spfm_entry_type            rd_data_ff;
   spfm_entry_type            wr_entry;
   logic                      wr_in_range;

   logic [ADDR_W-1:0]         q_high_ff, q_low_ff;
   logic                      q_is6_ff;

   logic [COUNT_W-1:0]        count_ff;
   logic                      perm_ff, temp_ff;
   logic [CODE_W-1:0]         neutral_ff;

   logic [2*ADDR_W-1:0]       diff;
   logic [2*ADDR_W-1:0]       mask;
   logic [PREFIX_W-1:0]       fam_limit;
   logic                      fam_match, pfx_ok;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      true_ff, true_in;
   logic [CODE_W-1:0]         code_ff, code_in;
   logic [INDEX_W-1:0]        idx_ff, idx_in;
   logic                      dflt_ff, dflt_in;

   assign csr_ready   = 1'b1;
   assign entry_count = count_ff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         perm_ff    <= 1'b0;
         temp_ff    <= 1'b0;
         neutral_ff <= NEUTRAL_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ENTRY_COUNT:  count_ff   <= csr_wdata;
            CSR_PERM_FAILED:  perm_ff    <= csr_wdata[0];
            CSR_TEMP_FAILED:  temp_ff    <= csr_wdata[0];
            CSR_NEUTRAL_CODE: neutral_ff <= csr_wdata[CODE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // entry table: one write port, one registered read port
   assign wr_in_range = (32'(req_entry_index) < 32'(TABLE_ENTRIES));
   always_comb begin
      wr_entry.addr_high  = req_addr_high;
      wr_entry.addr_low   = req_addr_low;
      wr_entry.prefix_len = req_prefix_len;
      wr_entry.tempfail   = req_flag_tempfail;
      wr_entry.any        = req_flag_any;
      wr_entry.ipv6       = req_flag_ipv6;
      wr_entry.ipv4       = req_flag_ipv4;
      wr_entry.mech_code  = req_mech_code;
   end

   always_ff @(posedge clock) begin
      if (cmd.write_entry && wr_in_range) begin
         mem[IDX_W'(req_entry_index)] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // query registers
   always_ff @(posedge clock) begin
      if (cmd.load_query) begin
         q_high_ff <= req_addr_high;
         q_low_ff  <= req_addr_low;
         q_is6_ff  <= req_query_is_ipv6;
      end
   end

   // compare the entry held in the read register against the query
   always_comb begin
      fam_match = (rd_data_ff.ipv6 && q_is6_ff) || (rd_data_ff.ipv4 && !q_is6_ff);
      fam_limit = q_is6_ff ? IPV6_BITS : IPV4_BITS;
      diff      = {rd_data_ff.addr_high ^ q_high_ff, rd_data_ff.addr_low ^ q_low_ff};
      mask      = ~({(2*ADDR_W){1'b1}} >> rd_data_ff.prefix_len);
      pfx_ok    = (rd_data_ff.prefix_len <= fam_limit) && ((diff & mask) == '0);
      status.hit = !rd_data_ff.tempfail && (fam_match ? pfx_ok : rd_data_ff.any);
      status.rsp_free = !rsp_valid_ff || rsp_ready;
   end

   // result selection
   always_comb begin
      if (cmd.use_default) begin
         true_in = 1'b1;
         code_in = neutral_ff;
         idx_in  = '0;
         dflt_in = 1'b1;
      end else begin
         idx_in  = INDEX_W'(match_idx);
         dflt_in = 1'b0;
         if (rd_data_ff.any && perm_ff) begin
            true_in = 1'b0;
            code_in = VERDICT_PERM;
         end else if (rd_data_ff.any && temp_ff) begin
            true_in = 1'b0;
            code_in = VERDICT_TEMP;
         end else begin
            true_in = 1'b1;
            code_in = rd_data_ff.mech_code;
         end
      end
   end

   // output register
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         true_ff <= true_in;
         code_ff <= code_in;
         idx_ff  <= idx_in;
         dflt_ff <= dflt_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_verdict_true  = true_ff;
   assign rsp_verdict_code  = code_ff;
   assign rsp_matched_index = idx_ff;
   assign rsp_used_default  = dflt_ff;

endmodule

/* src/spfm_checker.sv */
// Port-level checker for the SPF prefix match block, with its bind.
`timescale 1ns / 1ps
`include "spf_ip_prefix_first_match_assert.svh"
module spfm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                req_mode,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_verdict_true,
   input logic [spfm_pkg::CODE_W-1:0]         rsp_verdict_code,
   input logic [spfm_pkg::INDEX_W-1:0]        rsp_matched_index,
   input logic                                rsp_used_default
);
   import spfm_pkg::*;

   logic                        rsp_stall;
   logic                        chk_xfer;
   logic                        rsp_dflt;
   logic                        rsp_err;
   logic                        dflt_ok;
   logic                        err_code_ok;
   logic [CODE_W+INDEX_W+1:0]   rsp_fields;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign chk_xfer    = req_valid && req_ready && (req_mode == MODE_CHECK);
   assign rsp_dflt    = rsp_valid && rsp_used_default;
   assign rsp_err     = rsp_valid && !rsp_verdict_true;
   assign dflt_ok     = rsp_verdict_true && (rsp_matched_index == '0);
   assign err_code_ok = (rsp_verdict_code == VERDICT_PERM) ||
                        (rsp_verdict_code == VERDICT_TEMP);
   assign rsp_fields  = {rsp_verdict_true, rsp_verdict_code, rsp_matched_index,
                         rsp_used_default};

   `SPFM_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid, "result dropped while stalled")
   `SPFM_ASSERT_NEXT(a_rsp_stable, rsp_stall, $stable(rsp_fields), "held result changed")
   `SPFM_ASSERT_NEXT(a_check_busy, chk_xfer, !req_ready, "transfer taken during a check")
   `SPFM_ASSERT_SAME(a_default_form, rsp_dflt, dflt_ok, "default verdict malformed")
   `SPFM_ASSERT_SAME(a_error_code, rsp_err, err_code_ok, "bad error code")

endmodule

bind spf_ip_prefix_first_match spfm_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_mode          (req_mode),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_verdict_true  (rsp_verdict_true),
   .rsp_verdict_code  (rsp_verdict_code),
   .rsp_matched_index (rsp_matched_index),
   .rsp_used_default  (rsp_used_default)
);

/* tb/tb_spf_ip_prefix_first_match.sv */
// Testbench of the SPF first-match prefix block: queued stimulus, in-line table predictor.
`timescale 1ns / 1ps
module tb_spf_ip_prefix_first_match;
   import spfm_pkg::*;

   localparam int TABLE_ENTRIES = 16;
   localparam int RESET_CYCLES  = 4;
   // A check walks at most TABLE_ENTRIES entries before its verdict is ready;
   // give it ample room before touching the config registers.
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_PHASES = 20;
   localparam int PHASE_ITEMS   = 30;
   localparam int HOLD_CYCLES   = 150;

   // One request as the sender presents it on the req channel.
   typedef struct {
      logic                mode;
      logic [INDEX_W-1:0]  index;
      logic [CODE_W-1:0]   mech;
      logic                flag_v4;
      logic                flag_v6;
      logic                flag_any;
      logic                flag_tf;
      logic [PREFIX_W-1:0] plen;
      logic [ADDR_W-1:0]   addr_hi;
      logic [ADDR_W-1:0]   addr_lo;
      logic                query_v6;
   } acl_item_type;

   // One verdict as it should appear on the rsp channel.
   typedef struct packed {
      logic               ok;
      logic [CODE_W-1:0]  code;
      logic [INDEX_W-1:0] index;
      logic               dflt;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_mode = MODE_WRITE;
   logic [INDEX_W-1:0]    req_entry_index = '0;
   logic [CODE_W-1:0]     req_mech_code = '0;
   logic                  req_flag_ipv4 = 1'b0;
   logic                  req_flag_ipv6 = 1'b0;
   logic                  req_flag_any = 1'b0;
   logic                  req_flag_tempfail = 1'b0;
   logic [PREFIX_W-1:0]   req_prefix_len = '0;
   logic [ADDR_W-1:0]     req_addr_high = '0;
   logic [ADDR_W-1:0]     req_addr_low = '0;
   logic                  req_query_is_ipv6 = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_verdict_true;
   logic [CODE_W-1:0]     rsp_verdict_code;
   logic [INDEX_W-1:0]    rsp_matched_index;
   logic                  rsp_used_default;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Table and register image kept by the predictor.
   spfm_entry_type     acl_table [TABLE_ENTRIES];
   logic [COUNT_W-1:0] cfg_count   = '0;
   logic               cfg_perm    = 1'b0;
   logic               cfg_temp    = 1'b0;
   logic [CODE_W-1:0]  cfg_neutral = NEUTRAL_RESET;

   acl_item_type pending_items [$];
   verdict_type  verdict_q [$];
   acl_item_type in_flight;
   verdict_type  want;

   int  err_count = 0;
   int  gap_max   = 0;   // sender idle cycles drawn per transfer, 0..gap_max
   int  stall_max = 0;   // receiver stall cycles drawn per transfer, 0..stall_max
   int  send_wait = 0;
   int  rsp_wait  = 0;
   int  hold_left = 0;   // long receiver hold-off, counted down below
   logic req_taken = 1'b0;

   spf_ip_prefix_first_match #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_entry_index  (req_entry_index),
      .req_mech_code    (req_mech_code),
      .req_flag_ipv4    (req_flag_ipv4),
      .req_flag_ipv6    (req_flag_ipv6),
      .req_flag_any     (req_flag_any),
      .req_flag_tempfail(req_flag_tempfail),
      .req_prefix_len   (req_prefix_len),
      .req_addr_high    (req_addr_high),
      .req_addr_low     (req_addr_low),
      .req_query_is_ipv6(req_query_is_ipv6),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_verdict_true (rsp_verdict_true),
      .rsp_verdict_code (rsp_verdict_code),
      .rsp_matched_index(rsp_matched_index),
      .rsp_used_default (rsp_used_default),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor: store an entry, or walk the table for the first match.
   // ------------------------------------------------------------------
   function automatic void apply_item(input acl_item_type it);
      int             n;
      int             lim;
      logic [127:0]   mask;
      logic [127:0]   diff;
      logic           hit;
      spfm_entry_type e;
      verdict_type    v;
      if (it.mode == MODE_WRITE) begin
         acl_table[it.index] = '{addr_high: it.addr_hi, addr_low: it.addr_lo,
                                 prefix_len: it.plen, tempfail: it.flag_tf,
                                 any: it.flag_any, ipv6: it.flag_v6,
                                 ipv4: it.flag_v4, mech_code: it.mech};
         return;
      end
      // Counts beyond the table walk the whole table.
      n = (int'(cfg_count) > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(cfg_count);
      v = '{ok: 1'b1, code: cfg_neutral, index: '0, dflt: 1'b1};
      for (int i = 0; i < n; i++) begin
         e = acl_table[i];
         hit = 1'b0;
         if (e.tempfail)
            continue;
         if ((e.ipv6 && it.query_v6) || (e.ipv4 && !it.query_v6)) begin
            lim = it.query_v6 ? int'(IPV6_BITS) : int'(IPV4_BITS);
            // A prefix longer than the address family never matches.
            if (int'(e.prefix_len) <= lim) begin
               mask = {128{1'b1}};
               mask = mask << (128 - int'(e.prefix_len));
               diff = {e.addr_high, e.addr_low} ^ {it.addr_hi, it.addr_lo};
               hit = ((diff & mask) == '0);
            end
         end else if (e.any) begin
            hit = 1'b1;
         end
         if (hit) begin
            v.index = INDEX_W'(i);
            v.dflt = 1'b0;
            // A failed record overrides an all match; perm wins over temp.
            if (e.any && cfg_perm) begin
               v.ok = 1'b0;
               v.code = VERDICT_PERM;
            end else if (e.any && cfg_temp) begin
               v.ok = 1'b0;
               v.code = VERDICT_TEMP;
            end else begin
               v.ok = 1'b1;
               v.code = e.mech_code;
            end
            break;
         end
      end
      verdict_q.push_back(v);
   endfunction

   // ------------------------------------------------------------------
   // Item builders.
   // ------------------------------------------------------------------
   function automatic acl_item_type rand_fields();
      acl_item_type it;
      it.mode     = 1'($urandom);
      it.index    = INDEX_W'($urandom);
      it.mech     = CODE_W'($urandom);
      it.flag_v4  = 1'($urandom);
      it.flag_v6  = 1'($urandom);
      it.flag_any = 1'($urandom);
      it.flag_tf  = 1'($urandom);
      it.plen     = PREFIX_W'($urandom);
      it.addr_hi  = {$urandom, $urandom};
      it.addr_lo  = {$urandom, $urandom};
      it.query_v6 = 1'($urandom);
      return it;
   endfunction

   function automatic acl_item_type mk_entry(input int slot, input int mech, input bit v4,
                                             input bit v6, input bit anyf, input bit tf,
                                             input int plen, input logic [ADDR_W-1:0] hi,
                                             input logic [ADDR_W-1:0] lo);
      acl_item_type it;
      it = rand_fields();
      it.mode     = MODE_WRITE;
      it.index    = INDEX_W'(slot);
      it.mech     = CODE_W'(mech);
      it.flag_v4  = v4;
      it.flag_v6  = v6;
      it.flag_any = anyf;
      it.flag_tf  = tf;
      it.plen     = PREFIX_W'(plen);
      it.addr_hi  = hi;
      it.addr_lo  = lo;
      return it;
   endfunction

   function automatic acl_item_type mk_check(input bit q6, input logic [ADDR_W-1:0] hi,
                                             input logic [ADDR_W-1:0] lo);
      acl_item_type it;
      it = rand_fields();
      it.mode     = MODE_CHECK;
      it.query_v6 = q6;
      it.addr_hi  = hi;
      it.addr_lo  = lo;
      return it;
   endfunction

   // Random entry, mostly with a prefix that fits its family.
   function automatic acl_item_type rand_entry(input int slot);
      acl_item_type it;
      int           fam;
      it = rand_fields();
      it.mode     = MODE_WRITE;
      it.index    = INDEX_W'(slot);
      fam         = $urandom_range(0, 9);
      it.flag_v4  = (fam < 4) || (fam == 8);
      it.flag_v6  = (fam >= 4 && fam < 8) || (fam == 8);
      it.flag_any = ($urandom_range(0, 5) == 0);
      it.flag_tf  = ($urandom_range(0, 6) == 0);
      if ($urandom_range(0, 9) == 0)
         it.plen = PREFIX_W'($urandom_range(0, 255));
      else if (it.flag_v6)
         it.plen = PREFIX_W'($urandom_range(0, 128));
      else
         it.plen = PREFIX_W'($urandom_range(0, 32));
      return it;
   endfunction

   // Query mostly aimed at a table entry, with at most one address bit flipped.
   function automatic acl_item_type rand_check();
      acl_item_type   it;
      spfm_entry_type e;
      logic [127:0]   a;
      int             pos;
      it = rand_fields();
      it.mode = MODE_CHECK;
      if ($urandom_range(0, 9) < 7) begin
         e = acl_table[$urandom_range(0, TABLE_ENTRIES - 1)];
         if (e.ipv6 && !e.ipv4)
            it.query_v6 = 1'b1;
         else if (e.ipv4 && !e.ipv6)
            it.query_v6 = 1'b0;
         a = {e.addr_high, e.addr_low};
         pos = $urandom_range(0, 127);
         if ($urandom_range(0, 2) != 0)
            a[pos] = ~a[pos];
         {it.addr_hi, it.addr_lo} = a;
         // Bits outside an IPv4 address are don't-care; scramble them.
         if (!it.query_v6) begin
            it.addr_hi[31:0] = $urandom;
            it.addr_lo = {$urandom, $urandom};
         end
      end
      return it;
   endfunction

   // ------------------------------------------------------------------
   // Register access and sequencing.
   // ------------------------------------------------------------------
   // Leaves csr_valid high so back-to-back writes never drop it; the caller
   // lowers it after the last one.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      case (idx)
         CSR_ENTRY_COUNT:  cfg_count = value;
         CSR_PERM_FAILED:  cfg_perm = value[0];
         CSR_TEMP_FAILED:  cfg_temp = value[0];
         CSR_NEUTRAL_CODE: cfg_neutral = value[CODE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input int count, input bit perm, input bit temp,
                             input int neutral);
      logic [CSR_DATA_W-1:0] data;
      write_csr(CSR_ENTRY_COUNT, CSR_DATA_W'(count));
      // Upper data bits of the one-bit and two-bit registers carry noise.
      data = CSR_DATA_W'($urandom);
      data[0] = perm;
      write_csr(CSR_PERM_FAILED, data);
      data = CSR_DATA_W'($urandom);
      data[0] = temp;
      write_csr(CSR_TEMP_FAILED, data);
      data = CSR_DATA_W'($urandom);
      data[CODE_W-1:0] = CODE_W'(neutral);
      write_csr(CSR_NEUTRAL_CODE, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Block until every queued item is transferred and every verdict is back,
   // then let a trailing table write finish.
   task automatic wait_drained();
      @(posedge clock);
      while (pending_items.size() != 0 || req_valid || verdict_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] exp_val);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, exp_val);
      err_count++;
   endtask

   // ------------------------------------------------------------------
   // Request driver: launch at the falling edge, hold until the transfer.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_taken) begin
            // hold payload until the block takes it
         end else if (send_wait > 0) begin
            send_wait--;
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            in_flight = pending_items.pop_front();
            req_mode          <= in_flight.mode;
            req_entry_index   <= in_flight.index;
            req_mech_code     <= in_flight.mech;
            req_flag_ipv4     <= in_flight.flag_v4;
            req_flag_ipv6     <= in_flight.flag_v6;
            req_flag_any      <= in_flight.flag_any;
            req_flag_tempfail <= in_flight.flag_tf;
            req_prefix_len    <= in_flight.plen;
            req_addr_high     <= in_flight.addr_hi;
            req_addr_low      <= in_flight.addr_lo;
            req_query_is_ipv6 <= in_flight.query_v6;
            req_valid         <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
         req_taken = 1'b0;
      end
   end

   // Predict on each request transfer and draw the idle gap before the next.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         apply_item(in_flight);
         req_taken = 1'b1;
         send_wait = $urandom_range(0, gap_max);
      end
   end

   // ------------------------------------------------------------------
   // Result side: ready at the falling edge, check at the rising edge.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0)
         hold_left <= hold_left - 1;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdict_q.size() == 0) begin
            report_mismatch("verdict with no check outstanding", 8'h0, 8'h0);
         end else begin
            want = verdict_q.pop_front();
            if (rsp_verdict_true !== want.ok)
               report_mismatch("verdict_true", 8'(rsp_verdict_true), 8'(want.ok));
            if (rsp_verdict_code !== want.code)
               report_mismatch("verdict_code", 8'(rsp_verdict_code), 8'(want.code));
            if (rsp_matched_index !== want.index)
               report_mismatch("matched_index", 8'(rsp_matched_index), 8'(want.index));
            if (rsp_used_default !== want.dflt)
               report_mismatch("used_default", 8'(rsp_used_default), 8'(want.dflt));
         end
         rsp_wait = $urandom_range(0, stall_max);
      end
   end

   // ------------------------------------------------------------------
   // Stimulus.
   // ------------------------------------------------------------------
   initial begin
      int count_sel;
      int count;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      gap_max = 3;
      stall_max = 3;

      // Reset config: empty walk, neutral default code.
      pending_items.push_back(mk_check(1'b0, '0, '0));
      pending_items.push_back(mk_check(1'b1, '1, '1));
      wait_drained();

      // Small table: skipped tempfail, over-long prefixes, /32 and /128 of
      // all ones, and an all entry with no family flag at the end.
      pending_items.push_back(mk_entry(0, 1, 1, 0, 0, 1, 24, {32'h0A010200, 32'h0}, '0));
      pending_items.push_back(mk_entry(1, 3, 1, 0, 0, 0, 33, '0, '0));
      pending_items.push_back(mk_entry(2, 0, 1, 0, 0, 0, 32, '1, '0));
      pending_items.push_back(mk_entry(3, 3, 0, 1, 0, 0, 128, '1, '1));
      pending_items.push_back(mk_entry(4, 1, 0, 1, 0, 0, 255, '0, '0));
      pending_items.push_back(mk_entry(5, 2, 1, 0, 0, 0, 24, {32'h0A010200, 32'h0}, '0));
      pending_items.push_back(mk_entry(6, 1, 0, 0, 1, 0, 0, '0, '0));
      wait_drained();
      set_config(7, 0, 0, NEUTRAL_RESET);
      // IPv4 query: only the top 32 bits of addr_high count.
      pending_items.push_back(mk_check(1'b0, {32'h0A01024D, $urandom}, {$urandom, $urandom}));
      pending_items.push_back(mk_check(1'b0, {32'hFFFFFFFF, $urandom}, {$urandom, $urandom}));
      pending_items.push_back(mk_check(1'b1, '1, '1));
      pending_items.push_back(mk_check(1'b1, {$urandom, $urandom}, {$urandom, $urandom}));
      pending_items.push_back(mk_check(1'b0, {32'h0B000001, $urandom}, {$urandom, $urandom}));
      wait_drained();

      // Failed record on an all match; perm beats temp.
      set_config(7, 1, 0, NEUTRAL_RESET);
      pending_items.push_back(mk_check(1'b1, {$urandom, $urandom}, {$urandom, $urandom}));
      pending_items.push_back(mk_check(1'b0, {32'h0A010201, $urandom}, {$urandom, $urandom}));
      wait_drained();
      set_config(7, 1, 1, 3);
      pending_items.push_back(mk_check(1'b1, {$urandom, $urandom}, {$urandom, $urandom}));
      wait_drained();
      set_config(7, 0, 1, 0);
      pending_items.push_back(mk_check(1'b0, {32'h0C000001, $urandom}, {$urandom, $urandom}));
      wait_drained();

      // No match with a zero neutral code, then a dual-family /0 entry.
      set_config(5, 0, 0, 0);
      pending_items.push_back(mk_check(1'b1, {$urandom, $urandom}, {$urandom, $urandom}));
      pending_items.push_back(mk_entry(4, 1, 1, 1, 0, 0, 0, '0, '0));
      pending_items.push_back(mk_check(1'b0, {32'hC0A80001, $urandom}, {$urandom, $urandom}));
      wait_drained();
      set_config(0, 0, 0, 3);
      pending_items.push_back(mk_check(1'b1, {$urandom, $urandom}, {$urandom, $urandom}));
      wait_drained();

      // Fill every slot so that any entry count is legal from here on.
      gap_max = 12;
      stall_max = 12;
      for (int s = 0; s < TABLE_ENTRIES; s++)
         pending_items.push_back(rand_entry(s));
      wait_drained();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         count_sel = $urandom_range(0, 9);
         case (count_sel)
            0: count = 0;
            1: count = 1;
            2: count = TABLE_ENTRIES;
            3: count = $urandom_range(TABLE_ENTRIES + 1, 31);
            default: count = $urandom_range(2, TABLE_ENTRIES);
         endcase
         set_config(count, $urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0,
                    $urandom_range(0, 3));
         // Some phases run back to back on one or both sides.
         gap_max = (p % 4 == 3) ? 0 : 12;
         stall_max = (p % 5 == 2) ? 0 : 12;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(0, 3) == 0)
               pending_items.push_back(rand_entry($urandom_range(0, TABLE_ENTRIES - 1)));
            else
               pending_items.push_back(rand_check());
         end
         wait_drained();
      end

      // Back-pressure: hold the result side off while checks keep coming,
      // so the output register fills and req_ready drops.
      set_config(TABLE_ENTRIES, 0, 0, 1);
      gap_max = 0;
      stall_max = 0;
      hold_left = HOLD_CYCLES;
      for (int k = 0; k < 16; k++)
         pending_items.push_back(rand_check());
      wait_drained();

      if (err_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Watchdog on a hung handshake.
   initial begin
      #5000000;
      $display("Verification failed");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+src
src/spfm_pkg.sv
src/spfm_ctrl.sv
src/spfm_datapath.sv
src/spf_ip_prefix_first_match.sv
src/spfm_checker.sv
tb/tb_spf_ip_prefix_first_match.sv
